FILE: hw/rtl/closest_pair_brute_force_assert.svh
// Assertion macros for the port-level checker of the closest pair block.
// Depends on nothing; included by the checker.
`ifndef CLOSEST_PAIR_BRUTE_FORCE_ASSERT_SVH
`define CLOSEST_PAIR_BRUTE_FORCE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CPBF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CPBF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/cpbf_pkg.sv
// Package of the closest pair block: widths, reset constants and the point type.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package cpbf_pkg;

    localparam int NUM_POINTS_DEF = 8;
    localparam int COORD_W        = 32;
    localparam int IDX_OUT_W      = 3;
    localparam int SQ_W           = 2 * COORD_W;   // squared distance that can win
    localparam int ROOT_W         = COORD_W;

    // 2035000.0 in Q24.8
    localparam logic [COORD_W-1:0] LIMIT_RESET = 32'd520960000;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

endpackage

FILE: hw/rtl/cpbf_if.sv
// Channel interfaces of the closest pair block: point input, result output, limit write.
// Depends on cpbf_pkg.
`timescale 1ns / 1ps

interface cpbf_point_if;
    import cpbf_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;

    modport source (output valid, output point_x, output point_y, input ready);
    modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

interface cpbf_result_if;
    import cpbf_pkg::*;

    logic                        valid;
    logic                        ready;
    logic                        found;
    logic [IDX_OUT_W-1:0]        first_index;
    logic [IDX_OUT_W-1:0]        second_index;
    logic signed [COORD_W-1:0]   first_x;
    logic signed [COORD_W-1:0]   first_y;
    logic signed [COORD_W-1:0]   second_x;
    logic signed [COORD_W-1:0]   second_y;
    logic [COORD_W-1:0]          distance;

    modport source (output valid, output found, output first_index, output second_index,
                    output first_x, output first_y, output second_x, output second_y,
                    output distance, input ready);
    modport sink   (input valid, input found, input first_index, input second_index,
                    input first_x, input first_y, input second_x, input second_y,
                    input distance, output ready);
endinterface

interface cpbf_cfg_if;
    import cpbf_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] distance_limit;

    modport source (output valid, output distance_limit, input ready);
    modport sink   (input valid, input distance_limit, output ready);
endinterface

FILE: hw/rtl/closest_pair_brute_force.sv
// Closest pair of points, brute force. Takes NUM_POINTS points (signed Q24.8 x, y)
// one item per cycle into a point memory while loading; the item that completes a
// batch starts a search over every pair i < j in row order, keeping the first pair
// whose squared distance is strictly below both the squared limit and the best so
// far. One result item follows each batch. The search uses the single shared 32x32
// multiplier (limit squared, then dx^2 and dy^2 for each pair read from the memory's
// two read ports) and the floor square root unit that retires two radicand bits per
// cycle. Points of the next batch are not taken during the search, but they are
// taken while a finished result waits in the output register. Depends on cpbf_pkg,
// cpbf_if, cpbf_point_mem, cpbf_isqrt.
`timescale 1ns / 1ps

module closest_pair_brute_force #(
    parameter int NUM_POINTS = cpbf_pkg::NUM_POINTS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    cpbf_cfg_if.sink      cfg,
    cpbf_point_if.sink    point_in,
    cpbf_result_if.source result_out
);
    import cpbf_pkg::*;

    localparam int IDX_W = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
    localparam int IXW   = (IDX_W > IDX_OUT_W) ? IDX_W : IDX_OUT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_POINTS - 1);
    localparam logic [IDX_W-1:0] LAST_I   = IDX_W'(NUM_POINTS - 2);

    // search sequencer
    localparam logic [3:0] ST_LOAD      = 4'd0;
    localparam logic [3:0] ST_LIM_MUL   = 4'd1;
    localparam logic [3:0] ST_LIM_SET   = 4'd2;
    localparam logic [3:0] ST_READ      = 4'd3;
    localparam logic [3:0] ST_DIFF      = 4'd4;
    localparam logic [3:0] ST_MUL_X     = 4'd5;
    localparam logic [3:0] ST_MUL_Y     = 4'd6;
    localparam logic [3:0] ST_CMP       = 4'd7;
    localparam logic [3:0] ST_SQRT_GO   = 4'd8;
    localparam logic [3:0] ST_SQRT_WAIT = 4'd9;

    logic [3:0]         state_reg,    state_next;
    logic [IDX_W-1:0]   load_cnt_reg, load_cnt_next;
    logic [IDX_W-1:0]   pi_reg,       pi_next;
    logic [IDX_W-1:0]   pj_reg,       pj_next;
    logic [IDX_W-1:0]   best_i_reg,   best_i_next;
    logic [IDX_W-1:0]   best_j_reg,   best_j_next;
    logic               found_reg,    found_next;
    logic [COORD_W-1:0] limit_reg,    limit_next;      // configured limit
    logic [COORD_W-1:0] lim_used_reg, lim_used_next;   // limit latched at batch end
    logic [SQ_W-1:0]    best_reg,     best_next;
    logic [COORD_W-1:0] dx_reg,       dx_next;
    logic [COORD_W-1:0] dy_reg,       dy_next;
    logic [SQ_W-1:0]    sqx_reg,      sqx_next;
    logic [SQ_W-1:0]    prod_reg;

    // output register
    logic                      out_valid_reg, out_valid_next;
    logic                      out_found_reg;
    logic [IDX_OUT_W-1:0]      out_fi_reg;
    logic [IDX_OUT_W-1:0]      out_si_reg;
    point_t                    out_fp_reg;
    point_t                    out_sp_reg;
    logic [COORD_W-1:0]        out_dist_reg;
    logic                      out_load;

    logic               in_fire;
    logic               cfg_fire;
    logic               out_free;
    logic [IDX_W-1:0]   rd_addr_a;
    logic [IDX_W-1:0]   rd_addr_b;
    point_t             rd_a;
    point_t             rd_b;
    point_t             wr_pt;
    logic [COORD_W-1:0] mul_a;
    logic [SQ_W-1:0]    prod_full;
    logic signed [COORD_W:0] dxs;
    logic signed [COORD_W:0] dys;
    logic [COORD_W:0]   dxm;
    logic [COORD_W:0]   dym;
    logic [SQ_W:0]      pair_sum;
    logic               better;
    logic               sqrt_start;
    logic               sqrt_done;
    logic [ROOT_W-1:0]  sqrt_root;
    logic [IXW-1:0]     bi_ext;
    logic [IXW-1:0]     bj_ext;

    assign cfg.ready      = 1'b1;
    assign cfg_fire       = cfg.valid;
    assign point_in.ready = (state_reg == ST_LOAD);
    assign in_fire        = point_in.valid && point_in.ready;
    assign out_free       = !out_valid_reg || result_out.ready;
    assign wr_pt          = '{x: point_in.point_x, y: point_in.point_y};

    // the result phase reads back the winning pair; otherwise the pair under test
    assign rd_addr_a = (state_reg == ST_SQRT_GO || state_reg == ST_SQRT_WAIT) ?
                       best_i_reg : pi_reg;
    assign rd_addr_b = (state_reg == ST_SQRT_GO || state_reg == ST_SQRT_WAIT) ?
                       best_j_reg : pj_reg;

    cpbf_point_mem #(
        .DEPTH (NUM_POINTS),
        .AW    (IDX_W)
    ) u_mem (
        .clk       (clk),
        .wr_en     (in_fire),
        .wr_addr   (load_cnt_reg),
        .wr_data   (wr_pt),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    assign sqrt_start = (state_reg == ST_SQRT_GO);

    cpbf_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (best_reg),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    // one shared squarer: limit, then dx, then dy
    always_comb
    begin
        unique case (state_reg)
            ST_LIM_MUL: mul_a = lim_used_reg;
            ST_MUL_X:   mul_a = dx_reg;
            default:    mul_a = dy_reg;
        endcase
    end
    assign prod_full = {{COORD_W{1'b0}}, mul_a} * {{COORD_W{1'b0}}, mul_a};

    // absolute differences; magnitude always fits 32 bits
    assign dxs = {rd_a.x[COORD_W-1], rd_a.x} - {rd_b.x[COORD_W-1], rd_b.x};
    assign dys = {rd_a.y[COORD_W-1], rd_a.y} - {rd_b.y[COORD_W-1], rd_b.y};
    assign dxm = dxs[COORD_W] ? (COORD_W+1)'(-dxs) : dxs;
    assign dym = dys[COORD_W] ? (COORD_W+1)'(-dys) : dys;

    // a sum that reaches 2^64 never beats the best, which stays below 2^64
    assign pair_sum = {1'b0, sqx_reg} + {1'b0, prod_reg};
    assign better   = pair_sum < {1'b0, best_reg};

    assign out_load = (state_reg == ST_SQRT_WAIT) && sqrt_done && out_free;

    always_comb
    begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        pi_next       = pi_reg;
        pj_next       = pj_reg;
        best_i_next   = best_i_reg;
        best_j_next   = best_j_reg;
        found_next    = found_reg;
        limit_next    = cfg_fire ? cfg.distance_limit : limit_reg;
        lim_used_next = lim_used_reg;
        best_next     = best_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        sqx_next      = sqx_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (load_cnt_reg == LAST_IDX)
                    begin
                        load_cnt_next = '0;
                        lim_used_next = limit_reg;
                        found_next    = 1'b0;
                        best_i_next   = '0;
                        best_j_next   = '0;
                        pi_next       = '0;
                        pj_next       = IDX_W'(1);
                        state_next    = ST_LIM_MUL;
                    end
                    else
                    begin
                        load_cnt_next = load_cnt_reg + 1'b1;
                    end
                end
            end
            ST_LIM_MUL:
            begin
                state_next = ST_LIM_SET;
            end
            ST_LIM_SET:
            begin
                best_next  = prod_reg;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                dx_next    = dxm[COORD_W-1:0];
                dy_next    = dym[COORD_W-1:0];
                state_next = ST_MUL_X;
            end
            ST_MUL_X:
            begin
                state_next = ST_MUL_Y;
            end
            ST_MUL_Y:
            begin
                sqx_next   = prod_reg;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (better)
                begin
                    best_next   = pair_sum[SQ_W-1:0];
                    best_i_next = pi_reg;
                    best_j_next = pj_reg;
                    found_next  = 1'b1;
                end
                if (pj_reg == LAST_IDX)
                begin
                    if (pi_reg == LAST_I)
                    begin
                        state_next = ST_SQRT_GO;
                    end
                    else
                    begin
                        pi_next    = pi_reg + 1'b1;
                        pj_next    = pi_reg + IDX_W'(2);
                        state_next = ST_READ;
                    end
                end
                else
                begin
                    pj_next    = pj_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_SQRT_GO:
            begin
                state_next = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT:
            begin
                if (out_load)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            load_cnt_reg  <= '0;
            pi_reg        <= '0;
            pj_reg        <= '0;
            best_i_reg    <= '0;
            best_j_reg    <= '0;
            found_reg     <= 1'b0;
            limit_reg     <= LIMIT_RESET;
            lim_used_reg  <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            load_cnt_reg  <= load_cnt_next;
            pi_reg        <= pi_next;
            pj_reg        <= pj_next;
            best_i_reg    <= best_i_next;
            best_j_reg    <= best_j_next;
            found_reg     <= found_next;
            limit_reg     <= limit_next;
            lim_used_reg  <= lim_used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        sqx_reg  <= sqx_next;
        prod_reg <= prod_full;
    end

    // indices are reported modulo 8
    assign bi_ext = IXW'(best_i_reg);
    assign bj_ext = IXW'(best_j_reg);

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_found_reg <= found_reg;
            if (found_reg)
            begin
                out_fi_reg   <= bi_ext[IDX_OUT_W-1:0];
                out_si_reg   <= bj_ext[IDX_OUT_W-1:0];
                out_fp_reg   <= rd_a;
                out_sp_reg   <= rd_b;
                out_dist_reg <= sqrt_root;
            end
            else
            begin
                out_fi_reg   <= '0;
                out_si_reg   <= '0;
                out_fp_reg   <= '0;
                out_sp_reg   <= '0;
                out_dist_reg <= lim_used_reg;
            end
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.found        = out_found_reg;
    assign result_out.first_index  = out_fi_reg;
    assign result_out.second_index = out_si_reg;
    assign result_out.first_x      = out_fp_reg.x;
    assign result_out.first_y      = out_fp_reg.y;
    assign result_out.second_x     = out_sp_reg.x;
    assign result_out.second_y     = out_sp_reg.y;
    assign result_out.distance     = out_dist_reg;

endmodule

FILE: hw/rtl/cpbf_point_mem.sv
// Point store: one write port, two registered read ports.
// Depends on cpbf_pkg.
`timescale 1ns / 1ps

module cpbf_point_mem #(
    parameter int DEPTH = cpbf_pkg::NUM_POINTS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  cpbf_pkg::point_t     wr_data,
    input  logic [AW-1:0]        rd_addr_a,
    input  logic [AW-1:0]        rd_addr_b,
    output cpbf_pkg::point_t     rd_data_a,
    output cpbf_pkg::point_t     rd_data_b
);
    import cpbf_pkg::*;

    point_t mem [DEPTH];
    point_t rd_a_reg;
    point_t rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

FILE: hw/rtl/cpbf_isqrt.sv
// Iterative floor square root, two radicand bits per cycle.
// Depends on cpbf_pkg.
`timescale 1ns / 1ps

module cpbf_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [cpbf_pkg::SQ_W-1:0]   value,
    output logic                        done,
    output logic [cpbf_pkg::ROOT_W-1:0] root
);
    import cpbf_pkg::*;

    localparam int STEP_W = $clog2(ROOT_W);
    localparam int REM_W  = ROOT_W + 2;

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic [STEP_W-1:0] step_reg,  step_next;
    logic [SQ_W-1:0]   val_reg,   val_next;
    logic [REM_W-1:0]  rem_reg,   rem_next;
    logic [ROOT_W-1:0] root_reg,  root_next;

    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  rem_sub;

    always_comb
    begin
        rem_sh  = {rem_reg, val_reg[SQ_W-1 -: 2]};
        trial   = {2'b00, root_reg, 2'b01};
        rem_sub = rem_sh - trial;

        busy_next = busy_reg;
        done_next = done_reg;
        step_next = step_reg;
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;

        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            step_next = '0;
            val_next  = value;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            val_next = {val_reg[SQ_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sub[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(ROOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

FILE: hw/rtl/cpbf_checker.sv
// Port-level checker for the closest pair block, bound to the top level.
// Depends on cpbf_pkg and closest_pair_brute_force_assert.svh.
`timescale 1ns / 1ps
`include "closest_pair_brute_force_assert.svh"

module cpbf_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic                            out_found,
    input logic [cpbf_pkg::IDX_OUT_W-1:0]  out_first_index,
    input logic [cpbf_pkg::IDX_OUT_W-1:0]  out_second_index,
    input logic [cpbf_pkg::COORD_W-1:0]    out_first_x,
    input logic [cpbf_pkg::COORD_W-1:0]    out_second_y,
    input logic [cpbf_pkg::COORD_W-1:0]    out_distance
);
    import cpbf_pkg::*;

    // a stalled result holds
    `CPBF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_distance) && $stable(out_found), "result dropped or changed while stalled")

    // a result taken while points are accepted is not followed by another at once
    `CPBF_ASSERT_NEXT(a_out_once, clk, rst_n, out_valid && out_ready && in_ready, !out_valid, "result repeated")

    // a result only appears after a search, never straight after a point
    `CPBF_ASSERT_SAME(a_out_after_search, clk, rst_n, $rose(out_valid), !$past(in_valid && in_ready), "result right after a point")

    // no pair found: pair fields read zero
    `CPBF_ASSERT_SAME(a_none_zero, clk, rst_n, out_valid && !out_found, out_first_index == '0 && out_second_index == '0 && out_first_x == '0 && out_second_y == '0, "empty result carries a pair")

endmodule

bind closest_pair_brute_force cpbf_checker u_cpbf_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (point_in.valid),
    .in_ready         (point_in.ready),
    .out_valid        (result_out.valid),
    .out_ready        (result_out.ready),
    .out_found        (result_out.found),
    .out_first_index  (result_out.first_index),
    .out_second_index (result_out.second_index),
    .out_first_x      (result_out.first_x),
    .out_second_y     (result_out.second_y),
    .out_distance     (result_out.distance)
);

FILE: sim/closest_pair_checker.sv
`timescale 1ns / 1ps
// Checker of the closest pair block: follows limit writes and point items, predicts the
// closest pair of every batch and compares each result item field by field.
// Depends on cpbf_pkg and the channel interfaces of cpbf_if.

module closest_pair_checker #(
    parameter int NUM_POINTS = cpbf_pkg::NUM_POINTS_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    cpbf_cfg_if    cfg,
    cpbf_point_if  pt,
    cpbf_result_if res,
    output int     fail_count,
    output int     awaited_count,
    output int     results_seen,
    output int     hits_seen
);
    import cpbf_pkg::*;

    typedef struct {
        logic                 found;
        logic [IDX_OUT_W-1:0] first_index;
        logic [IDX_OUT_W-1:0] second_index;
        logic [COORD_W-1:0]   first_x;
        logic [COORD_W-1:0]   first_y;
        logic [COORD_W-1:0]   second_x;
        logic [COORD_W-1:0]   second_y;
        logic [COORD_W-1:0]   distance;
    } pair_result_t;

    point_t             batch_pts [NUM_POINTS];
    int                 batch_fill;
    logic [COORD_W-1:0] limit_q;
    pair_result_t       awaited_pairs [$];

    // |a - b| of two signed coordinates, exact in 33 bits
    function automatic logic [COORD_W:0] abs_diff(logic [COORD_W-1:0] a,
                                                  logic [COORD_W-1:0] b);
        logic [COORD_W:0] d;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        return d[COORD_W] ? (~d + 1'b1) : d;
    endfunction

    // floor square root, one result bit per pass from the top
    function automatic logic [COORD_W-1:0] floor_root(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = COORD_W - 1; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root[COORD_W-1:0];
    endfunction

    // search all pairs i < j in row order; strict compare keeps the first of a tie
    function automatic pair_result_t nearest_pair();
        pair_result_t     r;
        logic [66:0]      best;
        logic [66:0]      sq;
        logic [COORD_W:0] ax;
        logic [COORD_W:0] ay;
        int               bi;
        int               bj;
        logic             hit;
        best = {35'd0, limit_q} * {35'd0, limit_q};
        hit  = 1'b0;
        bi   = 0;
        bj   = 0;
        for (int i = 0; i < NUM_POINTS; i++)
            for (int j = i + 1; j < NUM_POINTS; j++)
            begin
                ax = abs_diff(batch_pts[i].x, batch_pts[j].x);
                ay = abs_diff(batch_pts[i].y, batch_pts[j].y);
                sq = {34'd0, ax} * {34'd0, ax} + {34'd0, ay} * {34'd0, ay};
                if (sq < best)
                begin
                    best = sq;
                    bi   = i;
                    bj   = j;
                    hit  = 1'b1;
                end
            end
        r.found = hit;
        if (hit)
        begin
            r.first_index  = IDX_OUT_W'(bi);
            r.second_index = IDX_OUT_W'(bj);
            r.first_x      = batch_pts[bi].x;
            r.first_y      = batch_pts[bi].y;
            r.second_x     = batch_pts[bj].x;
            r.second_y     = batch_pts[bj].y;
            r.distance     = floor_root(best[63:0]);
        end
        else
        begin
            r.first_index  = '0;
            r.second_index = '0;
            r.first_x      = '0;
            r.first_y      = '0;
            r.second_x     = '0;
            r.second_y     = '0;
            r.distance     = limit_q;
        end
        return r;
    endfunction

    task automatic compare_field(string name, logic [COORD_W-1:0] want,
                                 logic [COORD_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        pair_result_t want;
        if (!rst_n)
        begin
            limit_q    = LIMIT_RESET;
            batch_fill = 0;
            awaited_pairs.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                limit_q = cfg.distance_limit;
            if (pt.valid && pt.ready)
            begin
                batch_pts[batch_fill] = {pt.point_x, pt.point_y};
                batch_fill++;
                if (batch_fill == NUM_POINTS)
                begin
                    batch_fill = 0;
                    awaited_pairs.push_back(nearest_pair());
                end
            end
            if (res.valid && res.ready)
            begin
                results_seen++;
                if (res.found === 1'b1)
                    hits_seen++;
                if (awaited_pairs.size() == 0)
                begin
                    $error("result item with no batch outstanding");
                    fail_count++;
                end
                else
                begin
                    want = awaited_pairs.pop_front();
                    compare_field("found", want.found, res.found);
                    compare_field("first_index", want.first_index, res.first_index);
                    compare_field("second_index", want.second_index, res.second_index);
                    compare_field("first_x", want.first_x, res.first_x);
                    compare_field("first_y", want.first_y, res.first_y);
                    compare_field("second_x", want.second_x, res.second_x);
                    compare_field("second_y", want.second_y, res.second_y);
                    compare_field("distance", want.distance, res.distance);
                end
            end
        end
        awaited_count = awaited_pairs.size();
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// Top of the closest pair testbench: clock, reset, point and limit stimulus, result
// back-pressure and the verdict. Depends on cpbf_pkg, cpbf_if, closest_pair_checker
// and the closest_pair_brute_force block.

module tb;
    import cpbf_pkg::*;

    localparam int NUM_POINTS = NUM_POINTS_DEF;
    localparam int ITEM_GOAL  = 950;   // random part stops once this many items went in
    localparam int QUIET_TAIL = 150;   // last items run with no idling at all
    localparam int LONG_HOLD  = 600;   // result side hold-off, well past one search
    localparam int HOLD_PHASE = 5;     // random phase that gets the long hold-off
    localparam int SETTLE     = 200;   // covers a full search plus root

    localparam logic [COORD_W-1:0] P_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] P_MIN = 32'h8000_0000;

    // how the points of one batch are laid out
    typedef enum int {
        SPREAD_WIDE,      // anywhere in the plane, rarely inside a limit
        SPREAD_CLUSTER,   // jitter around one base point
        SPREAD_TWIN,      // only two distinct points, lots of ties
        SPREAD_EXTREME    // coordinates from the edges of the range
    } spread_mode_e;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    cpbf_cfg_if    cfg_if ();
    cpbf_point_if  pt_if ();
    cpbf_result_if res_if ();

    int fail_count;
    int awaited_count;
    int results_seen;
    int hits_seen;

    int           items_sent;
    int           phase_count;
    int           limit_writes;
    int           idle_pct;        // chance per item / per cycle of an idle burst
    bit           long_hold_req;
    spread_mode_e mode;
    logic [COORD_W-1:0] base_x, base_y, alt_x, alt_y, reach;

    closest_pair_brute_force #(
        .NUM_POINTS (NUM_POINTS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_if),
        .point_in   (pt_if),
        .result_out (res_if)
    );

    closest_pair_checker #(
        .NUM_POINTS (NUM_POINTS)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_if),
        .pt            (pt_if),
        .res           (res_if),
        .fail_count    (fail_count),
        .awaited_count (awaited_count),
        .results_seen  (results_seen),
        .hits_seen     (hits_seen)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hard stop in case the block hangs or drops a result.
    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Result side. Ready moves only at the falling edge; random idle bursts, plus one
    // long hold-off on request so the block backs up into its input.
    initial
    begin
        int hold_left;
        hold_left    = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD - 1;
                res_if.ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < idle_pct)
            begin
                hold_left     = $urandom_range(0, 7);
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    // Offer one point item and wait for it to be taken. Entered and left at a
    // falling edge; valid stays high between back-to-back items.
    task automatic push_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        int gap_len;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            gap_len = $urandom_range(1, 8);
            pt_if.valid <= 1'b0;
            repeat (gap_len) @(negedge clk);
        end
        pt_if.valid   <= 1'b1;
        pt_if.point_x <= x;
        pt_if.point_y <= y;
        do
            @(posedge clk);
        while (!(pt_if.valid && pt_if.ready));
        items_sent++;
        @(negedge clk);
    endtask

    // Limit writes only go in while the block is idle.
    task automatic write_limit(input logic [COORD_W-1:0] value);
        cfg_if.valid          <= 1'b1;
        cfg_if.distance_limit <= value;
        do
            @(posedge clk);
        while (!(cfg_if.valid && cfg_if.ready));
        @(negedge clk);
        cfg_if.valid <= 1'b0;
        limit_writes++;
    endtask

    // Stop sending, wait for every outstanding result, then let a full search time
    // pass so a batch that just completed cannot still be running.
    task automatic settle();
        pt_if.valid <= 1'b0;
        while (awaited_count != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        phase_count++;
    endtask

    // Eight points on the corners and edge midpoints of the full range.
    task automatic push_grid();
        push_point(P_MIN, P_MIN);
        push_point(32'd0, P_MIN);
        push_point(P_MAX, P_MIN);
        push_point(P_MIN, 32'd0);
        push_point(P_MAX, 32'd0);
        push_point(P_MIN, P_MAX);
        push_point(32'd0, P_MAX);
        push_point(P_MAX, P_MAX);
    endtask

    function automatic logic [COORD_W-1:0] jitter(logic [COORD_W-1:0] span);
        logic [COORD_W-1:0] off;
        off = $urandom_range(0, span);
        return $urandom_range(0, 1) ? off : -off;
    endfunction

    function automatic logic [COORD_W-1:0] extreme_coord();
        case ($urandom_range(0, 5))
            0:       return P_MIN;
            1:       return P_MAX;
            2:       return 32'd0;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'd1;
            default: return P_MIN + 1;
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] pick_limit();
        case ($urandom_range(0, 6))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return LIMIT_RESET;
            3:       return $urandom;
            4:       return $urandom_range(0, 1 << 20);
            default: return $urandom_range(1 << 24, 1 << 30);
        endcase
    endfunction

    // Next random point. The layout is picked at the first item of every batch,
    // so a batch keeps one shape even when it straddles a phase boundary.
    task automatic next_point(output logic [COORD_W-1:0] x, output logic [COORD_W-1:0] y);
        if (items_sent % NUM_POINTS == 0)
        begin
            case ($urandom_range(0, 9))
                0, 1:          mode = SPREAD_WIDE;
                2, 3, 4, 5, 6: mode = SPREAD_CLUSTER;
                7:             mode = SPREAD_TWIN;
                default:       mode = SPREAD_EXTREME;
            endcase
            base_x = $urandom;
            base_y = $urandom;
            alt_x  = $urandom;
            alt_y  = $urandom;
            reach  = 32'd1 << $urandom_range(0, 30);
        end
        case (mode)
            SPREAD_WIDE:
            begin
                x = $urandom;
                y = $urandom;
            end
            SPREAD_CLUSTER:
            begin
                x = base_x + jitter(reach);
                y = base_y + jitter(reach);
            end
            SPREAD_TWIN:
            begin
                x = $urandom_range(0, 1) ? base_x : alt_x;
                y = (x == base_x) ? base_y : alt_y;
            end
            default:
            begin
                x = extreme_coord();
                y = extreme_coord();
            end
        endcase
    endtask

    initial
    begin
        logic [COORD_W-1:0] px, py;
        int n_items;
        int rand_phase;

        pt_if.valid           = 1'b0;
        pt_if.point_x         = '0;
        pt_if.point_y         = '0;
        cfg_if.valid          = 1'b0;
        cfg_if.distance_limit = '0;
        idle_pct              = 10;
        long_hold_req         = 1'b0;
        mode                  = SPREAD_WIDE;
        rand_phase            = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset limit (2035000.0): the grid is far wider, so nothing is found and
        // the result carries the limit itself.
        push_grid();
        settle();

        // Widest limit: the grid now yields a pair, first one in row order.
        write_limit(32'hFFFF_FFFF);
        push_grid();
        settle();

        // Zero limit for the first half of a batch, then a new limit mid-batch:
        // the value at the last item counts. Pairs (0,1) and (2,3) tie at 1.0.
        write_limit(32'd0);
        push_point(32'd0, 32'd0);
        push_point(32'd256, 32'd0);
        push_point(32'h1000_0000, 32'hF000_0000);
        push_point(32'h1000_0000, 32'hF000_0000 - 32'd256);
        settle();
        write_limit(32'd1000);
        push_point(P_MIN, P_MIN);
        push_point(P_MAX, P_MIN);
        push_point(P_MIN, P_MAX);
        push_point(P_MAX, P_MAX);
        settle();

        // Random phases: a fresh limit now and then, a few batches each, sometimes
        // a partial batch so that loading spans a limit write.
        while (items_sent < ITEM_GOAL)
        begin
            if ($urandom_range(0, 1))
                write_limit(pick_limit());
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 10;
                default: idle_pct = 35;
            endcase
            if (items_sent >= ITEM_GOAL - QUIET_TAIL)
                idle_pct = 0;
            if (rand_phase == HOLD_PHASE)
            begin
                // keep offering items while results are held back for a long time
                long_hold_req = 1'b1;
                n_items       = 4 * NUM_POINTS;
            end
            else if ($urandom_range(0, 4) == 0)
                n_items = $urandom_range(1, 20);
            else
                n_items = NUM_POINTS * $urandom_range(1, 4);
            repeat (n_items)
            begin
                next_point(px, py);
                push_point(px, py);
            end
            settle();
            rand_phase++;
        end

        $display("Run covered %0d point items in %0d phases, %0d limit writes.",
                 items_sent, phase_count, limit_writes);
        $display("%0d result items checked, %0d with a pair inside the limit.",
                 results_seen, hits_seen);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
